// ===== sv/brfifo_pkg.sv =====
// Shared constants, codes and types of the byte ring FIFO with terminator seek.
package brfifo_pkg;

    localparam int DEPTH   = 1024;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int FIELD_W = 10;
    localparam int DATA_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int PAT_W   = 64;
    localparam int LEN_W   = 4;
    localparam int MAX_LEN = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = PAT_W;

    localparam int IN_FIELDS_W  = DATA_W + 2 * FIELD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + 2 * FIELD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DISCARD = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_SEEK    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TERM_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN     = 1'b1;

    localparam logic [PAT_W-1:0] TERM_PATTERN_RESET = 64'h0A0D;
    localparam logic [LEN_W-1:0] TERM_LEN_RESET     = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
        logic rd_finish;
        logic scan_step;
    } dp_cmd_t;

    typedef struct packed {
        logic seek_now;
        logic scan_done;
    } dp_status_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic               ok;
        logic [FIELD_W-1:0] count;
        logic [FIELD_W-1:0] fill;
    } result_t;

endpackage

// ===== sv/byte_ring_fifo_with_terminator_seek.sv =====
// Top level of the byte ring FIFO with terminator seek.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tuser func; tdata data_in, offset, amount
//  m_axis    out        m_axis_tvalid/tready      tuser ok; tdata data_out, count, fill_level
//  cfg       in         cfg_we (no wait)          cfg_index, cfg_data
//
// Push, discard, clear and unused codes write their result when the request is taken;
// pop and peek answer from the read state, behind the registered read port of the store.
// Seek answers when the request is taken if it resolves at once, else from the scan
// state, which reads one byte per cycle through the same read port.
// Reset zeroes both pointers; the store contents are not cleared and no sweep runs.
// A two-entry result queue lets a request be taken while one result waits downstream.
module byte_ring_fifo_with_terminator_seek
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] data_in, [17:8] offset, [27:18] amount, upper bits zero
    input  logic [brfifo_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] func
    input  logic [brfifo_pkg::FUNC_W-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [7:0] data_out, [17:8] count, [27:18] fill_level, upper bits zero
    output logic [brfifo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] ok
    output logic                                 m_axis_tuser,
    input  logic                                 cfg_we,
    input  logic [brfifo_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brfifo_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DATA_W  = brfifo_pkg::DATA_W;
    localparam int FIELD_W = brfifo_pkg::FIELD_W;

    brfifo_pkg::dp_cmd_t    cmd;
    brfifo_pkg::dp_status_t status;
    brfifo_pkg::result_t    res;
    brfifo_pkg::result_t    out_res;
    logic                   res_we;
    logic                   q_full;

    brfifo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .func      (s_axis_tuser),
        .q_full    (q_full),
        .status    (status),
        .in_tready (s_axis_tready),
        .cmd       (cmd)
    );

    brfifo_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .func      (s_axis_tuser),
        .data_in   (s_axis_tdata[DATA_W-1:0]),
        .offset    (s_axis_tdata[DATA_W+FIELD_W-1:DATA_W]),
        .amount    (s_axis_tdata[DATA_W+2*FIELD_W-1:DATA_W+FIELD_W]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .res_we    (res_we),
        .res       (res)
    );

    brfifo_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (res_we),
        .wr_data    (res),
        .q_full     (q_full),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_data   (out_res)
    );

    assign m_axis_tdata = brfifo_pkg::OUT_TDATA_W'({out_res.fill, out_res.count, out_res.data});
    assign m_axis_tuser = out_res.ok;

endmodule

// ===== sv/brfifo_ctrl.sv =====
// Controller state machine: request acceptance and sequencing of read and scan cycles.
module brfifo_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_tvalid,
    input  logic [brfifo_pkg::FUNC_W-1:0]  func,
    input  logic                           q_full,
    input  brfifo_pkg::dp_status_t         status,
    output logic                           in_tready,
    output brfifo_pkg::dp_cmd_t            cmd
);

    brfifo_pkg::ctrl_state_t state_reg;
    brfifo_pkg::ctrl_state_t state_next;
    logic                    in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brfifo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_tready     = 1'b0;
        in_fire       = 1'b0;
        cmd.exec      = 1'b0;
        cmd.rd_finish = 1'b0;
        cmd.scan_step = 1'b0;
        case (state_reg)
            brfifo_pkg::ST_IDLE:
            begin
                // hold off while both result slots are taken
                in_tready = !q_full;
                in_fire   = in_tvalid && !q_full;
                cmd.exec  = in_fire;
                if (in_fire)
                begin
                    if (func inside {brfifo_pkg::FUNC_POP, brfifo_pkg::FUNC_PEEK})
                    begin
                        state_next = brfifo_pkg::ST_READ;
                    end
                    else if (func == brfifo_pkg::FUNC_SEEK && !status.seek_now)
                    begin
                        state_next = brfifo_pkg::ST_SCAN;
                    end
                end
            end
            brfifo_pkg::ST_READ:
            begin
                cmd.rd_finish = 1'b1;
                state_next    = brfifo_pkg::ST_IDLE;
            end
            brfifo_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = brfifo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brfifo_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    ast_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != brfifo_pkg::ST_IDLE) |-> !in_tready)
        else $error("request accepted while busy");

    ast_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brfifo_pkg::ST_READ) |=> (state_reg == brfifo_pkg::ST_IDLE))
        else $error("read cycle did not return to idle");

    ast_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (func == brfifo_pkg::FUNC_POP || func == brfifo_pkg::FUNC_PEEK))
        |=> (state_reg == brfifo_pkg::ST_READ))
        else $error("pop or peek skipped the read cycle");
`endif

endmodule

// ===== sv/brfifo_dp.sv =====
// Datapath: byte store, ring pointers, terminator registers and seek matcher.
module brfifo_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  brfifo_pkg::dp_cmd_t                cmd,
    input  logic [brfifo_pkg::FUNC_W-1:0]      func,
    input  logic [brfifo_pkg::DATA_W-1:0]      data_in,
    input  logic [brfifo_pkg::FIELD_W-1:0]     offset,
    input  logic [brfifo_pkg::FIELD_W-1:0]     amount,
    input  logic                               cfg_we,
    input  logic [brfifo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brfifo_pkg::CFG_DATA_W-1:0]  cfg_data,
    output brfifo_pkg::dp_status_t             status,
    output logic                               res_we,
    output brfifo_pkg::result_t                res
);

    localparam int PTR_W   = brfifo_pkg::PTR_W;
    localparam int FIELD_W = brfifo_pkg::FIELD_W;
    localparam int DATA_W  = brfifo_pkg::DATA_W;
    localparam int LEN_W   = brfifo_pkg::LEN_W;
    localparam int CMP_W   = (PTR_W > FIELD_W) ? PTR_W : FIELD_W;

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + {1'b0, n};
        if (s >= (PTR_W+1)'(brfifo_pkg::DEPTH))
        begin
            s = s - (PTR_W+1)'(brfifo_pkg::DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] t,
                                                   input logic [PTR_W-1:0] h);
        logic [PTR_W:0] d;
        d = {1'b0, t} - {1'b0, h};
        if (t < h)
        begin
            d = d + (PTR_W+1)'(brfifo_pkg::DEPTH);
        end
        return d[PTR_W-1:0];
    endfunction

    logic [DATA_W-1:0]              byte_store_reg [brfifo_pkg::DEPTH];
    logic [DATA_W-1:0]              rd_data_reg;
    logic [PTR_W-1:0]               rd_addr;
    logic                           mem_we;

    logic [PTR_W-1:0]               head_reg, head_next;
    logic [PTR_W-1:0]               tail_reg, tail_next;
    logic [brfifo_pkg::PAT_W-1:0]   term_pattern_reg;
    logic [LEN_W-1:0]               term_len_reg;

    brfifo_pkg::result_t            pend_reg, pend_next;
    logic [LEN_W-1:0]               matched_reg, matched_next;
    logic [PTR_W-1:0]               scanned_reg, scanned_next;
    logic [PTR_W-1:0]               issue_reg, issue_next;

    logic [PTR_W-1:0]               held;
    logic [LEN_W-1:0]               len;
    logic [CMP_W-1:0]               disc_cmp;
    logic [PTR_W-1:0]               disc_n;
    logic [DATA_W-1:0]              pat_m0;
    logic [DATA_W-1:0]              pat_m1;
    logic [LEN_W-1:0]               m1;
    logic [LEN_W-1:0]               m2;
    logic                           found;

    // store has no reset: an entry's data is only returned after a push wrote it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_store_reg[tail_reg] <= data_in;
        end
        rd_data_reg <= byte_store_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            term_pattern_reg <= brfifo_pkg::TERM_PATTERN_RESET;
            term_len_reg     <= brfifo_pkg::TERM_LEN_RESET;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    brfifo_pkg::REG_TERM_PATTERN: term_pattern_reg <= cfg_data;
                    brfifo_pkg::REG_TERM_LEN:     term_len_reg <= cfg_data[LEN_W-1:0];
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        matched_reg <= matched_next;
        scanned_reg <= scanned_next;
        issue_reg   <= issue_next;
    end

    assign held = ring_fill(tail_reg, head_reg);
    assign len  = (term_len_reg > LEN_W'(brfifo_pkg::MAX_LEN)) ?
                  LEN_W'(brfifo_pkg::MAX_LEN) : term_len_reg;

    assign disc_cmp = (CMP_W'(amount) < CMP_W'(held)) ? CMP_W'(amount) : CMP_W'(held);
    assign disc_n   = PTR_W'(disc_cmp);

    // matcher: drop to position zero on a mismatch, then retest the same byte there
    assign pat_m0 = term_pattern_reg[{matched_reg[2:0], 3'b000} +: DATA_W];
    assign m1     = (rd_data_reg != pat_m0) ? '0 : matched_reg;
    assign pat_m1 = term_pattern_reg[{m1[2:0], 3'b000} +: DATA_W];
    assign m2     = (rd_data_reg == pat_m1) ? m1 + LEN_W'(1) : m1;
    assign found  = (m2 >= len);

    assign status.seek_now  = (len <= LEN_W'(1)) || (head_reg == tail_reg);
    assign status.scan_done = found || (issue_reg == tail_reg);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        mem_we       = 1'b0;
        rd_addr      = head_reg;
        pend_next    = pend_reg;
        matched_next = matched_reg;
        scanned_next = scanned_reg;
        issue_next   = issue_reg;
        res_we       = 1'b0;
        res          = '0;
        res.fill     = FIELD_W'(held);
        if (cmd.exec)
        begin
            pend_next      = '0;
            pend_next.fill = FIELD_W'(held);
            case (func)
                brfifo_pkg::FUNC_PUSH:
                begin
                    res_we = 1'b1;
                    if (held < PTR_W'(brfifo_pkg::DEPTH - 1))
                    begin
                        mem_we    = 1'b1;
                        tail_next = ring_add(tail_reg, PTR_W'(1));
                        res.ok    = 1'b1;
                        res.fill  = FIELD_W'(held + PTR_W'(1));
                    end
                end
                brfifo_pkg::FUNC_POP:
                begin
                    rd_addr = head_reg;
                    if (held != '0)
                    begin
                        head_next      = ring_add(head_reg, PTR_W'(1));
                        pend_next.ok   = 1'b1;
                        pend_next.fill = FIELD_W'(held - PTR_W'(1));
                    end
                end
                brfifo_pkg::FUNC_PEEK:
                begin
                    rd_addr      = ring_add(head_reg, PTR_W'(offset));
                    pend_next.ok = (CMP_W'(held) > CMP_W'(offset));
                end
                brfifo_pkg::FUNC_DISCARD:
                begin
                    res_we    = 1'b1;
                    head_next = ring_add(head_reg, disc_n);
                    res.count = FIELD_W'(disc_n);
                    res.fill  = FIELD_W'(held - disc_n);
                end
                brfifo_pkg::FUNC_CLEAR:
                begin
                    res_we    = 1'b1;
                    head_next = tail_reg;
                    res.fill  = '0;
                end
                brfifo_pkg::FUNC_SEEK:
                begin
                    if (status.seek_now)
                    begin
                        res_we = 1'b1;
                        res.ok = (len <= LEN_W'(1));
                    end
                    else
                    begin
                        // first pattern byte counts as matched before the scan
                        rd_addr      = head_reg;
                        issue_next   = ring_add(head_reg, PTR_W'(1));
                        matched_next = LEN_W'(1);
                        scanned_next = '0;
                    end
                end
                default:
                begin
                    res_we = 1'b1;
                end
            endcase
        end
        else if (cmd.rd_finish)
        begin
            res_we   = 1'b1;
            res      = pend_reg;
            res.data = pend_reg.ok ? rd_data_reg : '0;
        end
        else if (cmd.scan_step)
        begin
            if (status.scan_done)
            begin
                res_we    = 1'b1;
                res.ok    = found;
                res.count = found ? FIELD_W'(scanned_reg + PTR_W'(1)) : '0;
                res.fill  = pend_reg.fill;
            end
            else
            begin
                rd_addr      = issue_reg;
                issue_next   = ring_add(issue_reg, PTR_W'(1));
                scanned_next = scanned_reg + PTR_W'(1);
                matched_next = m2;
            end
        end
    end

endmodule

// ===== sv/brfifo_outq.sv =====
// Two-entry result queue between the datapath and the output stream.
module brfifo_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  brfifo_pkg::result_t  wr_data,
    output logic                 q_full,
    output logic                 out_tvalid,
    input  logic                 out_tready,
    output brfifo_pkg::result_t  out_data
);

    brfifo_pkg::result_t entry_reg [2];
    logic [1:0]          count_reg, count_next;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic                rd_en;

    assign out_tvalid = (count_reg != 2'd0);
    assign q_full     = (count_reg == 2'd2);
    assign rd_en      = out_tvalid && out_tready;
    assign out_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
